// File: rtl/dcfr_pkg.sv
// ----------------------------------------------------------------------------
// dcfr_pkg
// Types and constants for the delimited command frame receiver: beat
// payloads, opcodes, parser phases and the command pattern table.
// ----------------------------------------------------------------------------
package dcfr_pkg;

  // Pattern table geometry (fixed by the command set)
  localparam int unsigned CMD_TOTAL     = 17;
  localparam int unsigned PATTERN_BYTES = 3;

  // Command index reported when no pattern matches
  localparam logic [4:0] NO_MATCH = 5'd17;

  // Table entry that toggles the wag flag when a payload completes
  localparam int unsigned WAG_INDEX = 8;

  // Opcodes of an input beat
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_CONSUME = 2'd2
  } op_e;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_DATA = 3'b010,
    PH_TAIL = 3'b100
  } phase_e;

  // Reported parse_state codes
  localparam logic [1:0] PS_HEAD = 2'd0;
  localparam logic [1:0] PS_DATA = 2'd1;
  localparam logic [1:0] PS_TAIL = 2'd2;

  // Register reset values
  localparam logic [7:0] HEAD_RESET = 8'hFF;
  localparam logic [7:0] TAIL_RESET = 8'hFE;

  // Byte 0 of a pattern is the most significant byte of the literal
  typedef logic [0:PATTERN_BYTES-1][7:0] pattern_t;

  localparam pattern_t CMD_TABLE [CMD_TOTAL] = '{
    24'h000000, 24'hAAABAC, 24'hBABBBC, 24'hCACBCC, 24'hDADBDC, 24'hEAEBEC,
    24'hFAFBFC, 24'h0A0B0C, 24'h1A1B1C, 24'h2A2B2C, 24'h4A4B4C, 24'h5A5B5C,
    24'h6A6B6C, 24'h7A7B7C, 24'h8A8B8C, 24'h9A9B9C, 24'h1B3B5B
  };

  // Input beat
  typedef struct packed {
    logic [1:0] opcode;
    logic       source;
    logic [7:0] rx_byte;
  } in_t;

  // Result beat
  typedef struct packed {
    logic       frame_ready;
    logic [4:0] command;
    logic       wag_on;
    logic       error_seen;
    logic       timeout_pending;
    logic [1:0] parse_state;
  } out_t;

  // Decoder results handed to the parser
  typedef struct packed {
    logic [4:0] command;
    logic       wag_match;
  } dec_t;

endpackage

// File: rtl/dcfr_decode.sv
// ----------------------------------------------------------------------------
// dcfr_decode
// Compares the payload store against every command pattern in parallel and
// returns the first matching index plus the tail-wag match.
// ----------------------------------------------------------------------------
module dcfr_decode #(
  parameter int unsigned PAYLOAD_BYTES = 3,
  parameter int unsigned COMMAND_COUNT = 17
) (
  input  logic [PAYLOAD_BYTES-1:0][7:0] store_i,
  output dcfr_pkg::dec_t                dec_o
);
  import dcfr_pkg::*;

  logic [COMMAND_COUNT-1:0] match;

  // Compare each pattern over the live payload bytes
  always_comb begin
    for (int j = 0; j < COMMAND_COUNT; j++) begin
      match[j] = 1'b1;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        if (store_i[i] != CMD_TABLE[j][i]) begin
          match[j] = 1'b0;
        end
      end
    end
  end

  // Pick the lowest matching index, check the wag pattern
  always_comb begin
    dec_o.command   = NO_MATCH;
    dec_o.wag_match = 1'b1;
    for (int j = COMMAND_COUNT - 1; j >= 0; j--) begin
      if (match[j]) begin
        dec_o.command = 5'(j);
      end
    end
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (store_i[i] != CMD_TABLE[WAG_INDEX][i]) begin
        dec_o.wag_match = 1'b0;
      end
    end
  end

endmodule

// File: rtl/delimited_command_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver_unit
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless a stalled result beat holds the input; parser update
// and the parallel pattern compare sit between the state registers and the result register.
// Reset: parser waits for a head, positions, payload and flags clear,
// head/tail registers return to 0xFF/0xFE.
// ----------------------------------------------------------------------------
module delimited_command_frame_receiver_unit #(
  parameter int unsigned PAYLOAD_BYTES = 3,
  parameter int unsigned COMMAND_COUNT = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Input channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dcfr_pkg::in_t  in_data_i,
  // Result channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dcfr_pkg::out_t out_data_o,
  // Register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dcfr_pkg::*;

  localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 1);

  logic [7:0] head_q, tail_q;

  phase_e                        phase_q, phase_d;
  logic [1:0][PosW-1:0]          pos_q, pos_d;
  logic [PAYLOAD_BYTES-1:0][7:0] store_q, store_d;
  logic ready_q, ready_d;
  logic wag_q, wag_d;
  logic err_q, err_d;
  logic tmo_q, tmo_d;

  logic          accept;
  logic [PosW-1:0] pos_cur, pos_inc;
  dec_t          dec;
  out_t          out_q, out_d;
  logic          out_valid_q;

  // Register port: write on the access beat, read back any time
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'b0, tail_q} : {24'b0, head_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RESET;
      tail_q <= TAIL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        tail_q <= pwdata[7:0];
      end else begin
        head_q <= pwdata[7:0];
      end
    end
  end

  // Accept while the result register is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_cur = pos_q[in_data_i.source];
  assign pos_inc = pos_cur + PosW'(1);

  // Decode the updated payload
  dcfr_decode #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .COMMAND_COUNT (COMMAND_COUNT)
  ) u_decode (
    .store_i (store_d),
    .dec_o   (dec)
  );

  // Parser and flag update for one beat
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    store_d = store_q;
    ready_d = ready_q;
    wag_d   = wag_q;
    err_d   = err_q;
    tmo_d   = tmo_q;
    if (accept) begin
      unique case (in_data_i.opcode)
        OP_BYTE: begin
          unique case (phase_q)
            PH_DATA: begin
              for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                if (pos_cur == PosW'(i)) begin
                  store_d[i] = in_data_i.rx_byte;
                end
              end
              if (pos_inc == PosW'(PAYLOAD_BYTES)) begin
                pos_d[in_data_i.source] = '0;
                phase_d = PH_TAIL;
              end else begin
                pos_d[in_data_i.source] = pos_inc;
              end
            end
            PH_TAIL: begin
              if (in_data_i.rx_byte == tail_q) begin
                phase_d = PH_HEAD;
                ready_d = 1'b1;
                if (err_q) begin
                  err_d = 1'b0;
                  tmo_d = 1'b0;
                end
              end else if (tmo_q) begin
                // abort the frame
                tmo_d   = 1'b0;
                err_d   = 1'b0;
                ready_d = 1'b0;
                phase_d = PH_HEAD;
              end else begin
                err_d = 1'b1;
              end
            end
            default: begin
              if (in_data_i.rx_byte == head_q && !ready_q) begin
                phase_d = PH_DATA;
              end else begin
                phase_d = PH_HEAD;
              end
            end
          endcase
        end
        OP_TIMEOUT: tmo_d   = 1'b1;
        OP_CONSUME: ready_d = 1'b0;
        default: ;
      endcase
    end
    // toggle wag when the payload completes on the wag pattern
    if (accept && in_data_i.opcode == OP_BYTE && phase_q == PH_DATA &&
        pos_inc == PosW'(PAYLOAD_BYTES) && dec.wag_match) begin
      wag_d = !wag_q;
    end
  end

  // Build the result beat from the updated state
  always_comb begin
    out_d.frame_ready     = ready_d;
    out_d.command         = dec.command;
    out_d.wag_on          = wag_d;
    out_d.error_seen      = err_d;
    out_d.timeout_pending = tmo_d;
    unique case (phase_d)
      PH_DATA: out_d.parse_state = PS_DATA;
      PH_TAIL: out_d.parse_state = PS_TAIL;
      default: out_d.parse_state = PS_HEAD;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      pos_q   <= '0;
      store_q <= '0;
      ready_q <= 1'b0;
      wag_q   <= 1'b0;
      err_q   <= 1'b0;
      tmo_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      store_q <= store_d;
      ready_q <= ready_d;
      wag_q   <= wag_d;
      err_q   <= err_d;
      tmo_q   <= tmo_d;
    end
  end

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dcfr_checker.sv
// ----------------------------------------------------------------------------
// dcfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module dcfr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input dcfr_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dcfr_pkg::out_t out_data_o
);
  import dcfr_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // Hold a stalled result beat
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A new result only follows an accepted input beat
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_beat))
    else $error("result appeared without an input beat");

  // Consume clears the ready flag in its result
  a_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.opcode == OP_CONSUME |=> !out_data_o.frame_ready)
    else $error("consume left frame_ready set");

  // Timeout sets the pending flag in its result
  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.opcode == OP_TIMEOUT |=> out_data_o.timeout_pending)
    else $error("timeout not recorded");

endmodule

bind delimited_command_frame_receiver_unit dcfr_checker u_dcfr_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delimited command frame receiver. A sender
// task drives input beats under random gaps, a bit-accurate parser model
// predicts one status beat per accepted input, and a checker compares each
// status beat field by field in order. The head and tail registers are
// rewritten between phases over the register port and read back.
// ----------------------------------------------------------------------------
module tb;
  import dcfr_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0] ADDR_HEAD       = 3'd0;
  localparam logic [2:0] ADDR_TAIL       = 3'd4;
  localparam int         WAG_PATTERN_IDX = 8;
  localparam int         HOLD_CYCLES     = 80;
  localparam int         PHASE_BEATS     = 490;

  // Command patterns, first payload byte in the top byte
  localparam logic [23:0] PATTERNS [17] = '{
    24'h000000, 24'hAAABAC, 24'hBABBBC, 24'hCACBCC, 24'hDADBDC, 24'hEAEBEC,
    24'hFAFBFC, 24'h0A0B0C, 24'h1A1B1C, 24'h2A2B2C, 24'h4A4B4C, 24'h5A5B5C,
    24'h6A6B6C, 24'h7A7B7C, 24'h8A8B8C, 24'h9A9B9C, 24'h1B3B5B
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Parser model state, mirrors the block after each accepted beat
  logic [7:0] head_reg = HEAD_RESET;
  logic [7:0] tail_reg = TAIL_RESET;
  logic [1:0] phase    = PS_HEAD;
  logic [1:0] wr_pos [2] = '{2'd0, 2'd0};
  logic [7:0] payload [3] = '{8'h00, 8'h00, 8'h00};
  logic       ready_f  = 1'b0;
  logic       wag_f    = 1'b0;
  logic       err_f    = 1'b0;
  logic       tmo_f    = 1'b0;

  out_t        status_q [$];
  int          errors             = 0;
  int          beats_sent         = 0;
  int          results_checked    = 0;
  int          frames_closed      = 0;
  int          frames_aborted     = 0;
  int          wag_toggles        = 0;
  int          input_stall_cycles = 0;
  logic [17:0] cmd_hit            = '0;
  int          send_idle_pct      = 0;
  int          recv_idle_pct      = 0;
  int          hold_left          = 0;

  delimited_command_frame_receiver_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decode the payload store against the pattern table, first match wins
  function automatic logic [4:0] lookup_command();
    for (int j = 0; j < 17; j++) begin
      if ({payload[0], payload[1], payload[2]} == PATTERNS[j]) return 5'(j);
    end
    return NO_MATCH;
  endfunction

  // Apply one input beat to the model and return the status it reports
  function automatic out_t advance_parser(in_t b);
    out_t r;
    int   pos;
    case (b.opcode)
      OP_BYTE: begin
        case (phase)
          PS_DATA: begin
            pos = wr_pos[b.source];
            if (pos >= 3) pos = 0;
            payload[pos] = b.rx_byte;
            pos++;
            if (pos >= 3) begin
              pos = 0;
              if ({payload[0], payload[1], payload[2]} == PATTERNS[WAG_PATTERN_IDX]) begin
                wag_f = ~wag_f;
                wag_toggles++;
              end
              phase = PS_TAIL;
            end
            wr_pos[b.source] = 2'(pos);
          end
          PS_TAIL: begin
            if (b.rx_byte == tail_reg) begin
              phase   = PS_HEAD;
              ready_f = 1'b1;
              frames_closed++;
              if (err_f) begin
                tmo_f = 1'b0;
                err_f = 1'b0;
              end
            end else begin
              err_f = 1'b1;
              // a pending timeout turns the bad tail into an abort
              if (tmo_f) begin
                tmo_f   = 1'b0;
                err_f   = 1'b0;
                phase   = PS_HEAD;
                ready_f = 1'b0;
                frames_aborted++;
              end
            end
          end
          default: begin
            phase = (b.rx_byte == head_reg && !ready_f) ? PS_DATA : PS_HEAD;
          end
        endcase
      end
      OP_TIMEOUT: tmo_f = 1'b1;
      OP_CONSUME: ready_f = 1'b0;
      default: ;
    endcase
    r.frame_ready     = ready_f;
    r.command         = lookup_command();
    r.wag_on          = wag_f;
    r.error_seen      = err_f;
    r.timeout_pending = tmo_f;
    r.parse_state     = phase;
    return r;
  endfunction

  function automatic in_t make_beat(logic [1:0] op, logic src, logic [7:0] value);
    in_t b;
    b.opcode  = op;
    b.source  = src;
    b.rx_byte = value;
    return b;
  endfunction

  // Offer one beat after random gaps, hold it until accepted, then predict
  task automatic send_beat(input in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall);
    status_q.push_back(advance_parser(b));
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted status beat has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write one register, then read it back in the following transfer
  task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_HEAD) head_reg = value;
    else tail_reg = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'b0, value}) begin
      errors++;
      $display("%0t: readback of 0x%0h, expected 0x%0h, actual 0x%0h",
               $time, addr, {24'b0, value}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_delimiters(input logic [7:0] head, input logic [7:0] tail);
    pause_until_drained();
    write_register(ADDR_HEAD, head);
    write_register(ADDR_TAIL, tail);
  endtask

  // One frame with random content, now and then broken or preceded by events
  task automatic send_frame();
    logic        src;
    logic        mixed;
    logic [23:0] body;
    int          kind;
    src   = 1'($urandom_range(1));
    mixed = ($urandom_range(9) == 0);
    kind  = $urandom_range(9);
    if (ready_f && $urandom_range(9) < 8)
      send_beat(make_beat(OP_CONSUME, 1'($urandom_range(1)), 8'($urandom_range(255))));
    if ($urandom_range(7) == 0)
      send_beat(make_beat(OP_TIMEOUT, 1'($urandom_range(1)), 8'($urandom_range(255))));
    send_beat(make_beat(OP_BYTE, src,
                        ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : head_reg));
    if (kind < 2) body = PATTERNS[WAG_PATTERN_IDX];
    else if (kind < 6) body = PATTERNS[$urandom_range(16)];
    else body = 24'($urandom);
    for (int i = 0; i < 3; i++)
      send_beat(make_beat(OP_BYTE, mixed ? 1'($urandom_range(1)) : src, body[23-8*i -: 8]));
    if ($urandom_range(4) == 0)
      send_beat(make_beat(OP_BYTE, src, 8'($urandom_range(255))));
    send_beat(make_beat(OP_BYTE, src, tail_reg));
  endtask

  task automatic run_traffic(input int n);
    int start;
    start = beats_sent;
    while (beats_sent - start < n) begin
      if ($urandom_range(99) < 85) send_frame();
      else send_beat(make_beat(2'($urandom_range(3)), 1'($urandom_range(1)),
                               8'($urandom_range(255))));
    end
  endtask

  // Walk the named cases at reset delimiters
  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_beat(make_beat(OP_UNUSED, 1'b1, 8'hA5));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'hFF));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h1A));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h1B));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h1C));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'hFE));
    // head while a frame waits: ignored
    send_beat(make_beat(OP_BYTE, 1'b1, 8'hFF));
    send_beat(make_beat(OP_CONSUME, 1'b0, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'hFF));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'h1B));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'h3B));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'h5B));
    // bad tail raises the error, good tail then clears it
    send_beat(make_beat(OP_BYTE, 1'b1, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'hFE));
    send_beat(make_beat(OP_CONSUME, 1'b1, 8'hFF));
    send_beat(make_beat(OP_TIMEOUT, 1'b0, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'hFF));
    // mixed sources share one store; the head-valued byte closes the payload
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b1, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h00));
    send_beat(make_beat(OP_BYTE, 1'b0, 8'hFF));
    // bad tail with a timeout pending aborts the frame
    send_beat(make_beat(OP_BYTE, 1'b0, 8'h12));
    send_beat(make_beat(OP_TIMEOUT, 1'b1, 8'hFF));
    send_beat(make_beat(OP_UNUSED, 1'b0, 8'h00));
    pause_until_drained();
  endtask

  task automatic test_extreme_delimiters();
    set_delimiters(8'h00, 8'hFF);
    send_idle_pct = 23;
    recv_idle_pct = 46;
    run_traffic(PHASE_BEATS);
  endtask

  task automatic test_swapped_idling();
    set_delimiters(8'hFF, 8'h00);
    send_idle_pct = 46;
    recv_idle_pct = 23;
    run_traffic(PHASE_BEATS);
  endtask

  task automatic test_back_to_back();
    set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(PHASE_BEATS);
  endtask

  // Hold the result side off while the sender keeps offering beats
  task automatic test_output_backpressure();
    set_delimiters(HEAD_RESET, TAIL_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    run_traffic(60);
    pause_until_drained();
  endtask

  // Drive the result stall: a counted hold-off first, random otherwise
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && in_valid && in_stall) input_stall_cycles++;
    if (rst_ni && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %p", $time, out_data);
      end else begin
        want = status_q.pop_front();
        results_checked++;
        cmd_hit[want.command] = 1'b1;
        check_field("frame_ready", want.frame_ready, out_data.frame_ready);
        check_field("command", want.command, out_data.command);
        check_field("wag_on", want.wag_on, out_data.wag_on);
        check_field("error_seen", want.error_seen, out_data.error_seen);
        check_field("timeout_pending", want.timeout_pending, out_data.timeout_pending);
        check_field("parse_state", want.parse_state, out_data.parse_state);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", status_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_frames();
    test_extreme_delimiters();
    test_swapped_idling();
    test_back_to_back();
    test_output_backpressure();
    pause_until_drained();
    repeat (4) @(negedge clk_i);
    if (status_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, status_q.size());
    end
    $display("Sent %0d beats and checked %0d status beats: %0d frames closed,",
             beats_sent, results_checked, frames_closed);
    $display("%0d aborted, %0d wag toggles; saw %0d of 18 command codes; %0s %0d cycles",
             frames_aborted, wag_toggles, $countones(cmd_hit), "input held off for",
             input_stall_cycles);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: delimited_command_frame_receiver_unit.f
rtl/dcfr_pkg.sv
rtl/dcfr_decode.sv
rtl/delimited_command_frame_receiver_unit.sv
rtl/dcfr_checker.sv
test/tb.sv
